/* src/vmoa_pkg.sv */
// Shared types and constants for the VEX memory operand address resolver.
package vmoa_pkg;

  localparam int NUM_REGS  = 16;
  localparam int REG_SEL_W = $clog2(NUM_REGS);

  localparam logic       OP_WRITE   = 1'b0;
  localparam logic       OP_RESOLVE = 1'b1;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;

  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_DISP32   = 3'd5;
  localparam logic [2:0] SIB_NO_IDX  = 3'd4;
  localparam logic [2:0] SIB_NO_BASE = 3'd5;

  localparam logic [4:0] MAP_0F      = 5'd1;
  localparam logic [4:0] MAP_0F3A    = 5'd3;
  localparam logic [7:0] OPC_MOV_IMM = 8'hC6;

  // Decoded addressing form of one instruction.
  typedef struct packed {
    logic                 rip_rel;
    logic                 use_base;
    logic                 use_index;
    logic [REG_SEL_W-1:0] base_sel;
    logic [REG_SEL_W-1:0] index_sel;
    logic [1:0]           scale;
    logic signed [31:0]   disp;
    logic [3:0]           length;
  } dec_t;

endpackage

/* src/vmoa_decode.sv */
// ModRM, SIB, displacement and length decoder.
module vmoa_decode import vmoa_pkg::*; (
  input  logic [1:0]  prefix_len,
  input  logic        vex_b,
  input  logic        vex_x,
  input  logic [4:0]  vex_map,
  input  logic [7:0]  opcode,
  input  logic [7:0]  modrm,
  input  logic [39:0] tail_bytes,
  output dec_t        dec
);

  logic [1:0]  mod_f;
  logic [2:0]  rm;
  logic [7:0]  sib;
  logic        has_sib;
  logic        no_base;
  logic [2:0]  pos;
  logic        has_imm;
  logic [31:0] disp_at0;
  logic [31:0] disp_at1;
  logic [7:0]  d8;

  always_comb begin
    mod_f    = modrm[7:6];
    rm       = modrm[2:0];
    sib      = tail_bytes[7:0];
    has_sib  = (rm == RM_SIB);
    disp_at0 = tail_bytes[31:0];
    disp_at1 = tail_bytes[39:8];
    d8       = has_sib ? tail_bytes[15:8] : tail_bytes[7:0];

    dec.rip_rel   = 1'b0;
    dec.use_base  = 1'b1;
    dec.use_index = 1'b0;
    dec.base_sel  = {~vex_b, rm};
    dec.index_sel = {~vex_x, sib[5:3]};
    dec.scale     = 2'd0;
    dec.disp      = '0;
    pos           = 3'd0;
    no_base       = 1'b0;

    if (has_sib) begin
      pos           = 3'd1;
      dec.scale     = sib[7:6];
      dec.use_index = (sib[5:3] != SIB_NO_IDX);
      dec.base_sel  = {~vex_b, sib[2:0]};
      if (sib[2:0] == SIB_NO_BASE && mod_f == MOD_NO_DISP) begin
        // SIB with no base register takes a disp32 instead.
        no_base      = 1'b1;
        dec.use_base = 1'b0;
        dec.disp     = disp_at1;
        pos          = 3'd5;
      end
    end else if (mod_f == MOD_NO_DISP && rm == RM_DISP32) begin
      dec.rip_rel  = 1'b1;
      dec.use_base = 1'b0;
      dec.disp     = disp_at0;
      pos          = 3'd4;
    end

    // Only mod 0 forms carry the disp32 above, so these never add to it.
    case (mod_f)
      MOD_DISP8: begin
        dec.disp = 32'(signed'(d8));
        pos      = pos + 3'd1;
      end
      MOD_DISP32: begin
        dec.disp = has_sib ? disp_at1 : disp_at0;
        pos      = pos + 3'd4;
      end
      default: begin
        dec.disp = dec.disp;
      end
    endcase

    has_imm    = (vex_map == MAP_0F3A) || (vex_map == MAP_0F && opcode == OPC_MOV_IMM);
    dec.length = 4'(prefix_len) + 4'd2 + 4'(pos) + 4'(has_imm);
    if (no_base) begin
      dec.length = dec.length;
    end
  end

endmodule

/* src/vmoa_regfile.sv */
// General register file with two registered read ports and reset-cleared valid bits.
module vmoa_regfile import vmoa_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [REG_SEL_W-1:0]  wr_sel,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [REG_SEL_W-1:0]  rd_sel_a,
  input  logic [REG_SEL_W-1:0]  rd_sel_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   vld;

  // An entry not written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_sel] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= vld[rd_sel_a] ? mem[rd_sel_a] : '0;
      rd_data_b <= vld[rd_sel_b] ? mem[rd_sel_b] : '0;
    end
  end

endmodule

/* src/vex_memory_operand_address.sv */
// Top level of the VEX memory operand address resolver.
// Each input word either loads one of 16 general registers (op 0, no result) or resolves the
// memory operand of a VEX instruction (op 1, one result: effective address and length).
// A word can be accepted every clock while in_ready is high. For a resolve word, decode and
// the register file read are registered when the word is accepted, and the three-input
// address add is then registered in the result register. Back-pressure on the result only
// holds the input off once both the decode stage and the result register are full.
// A register write takes effect for every resolve word accepted after it. Registers read as
// zero after reset. Addresses wrap modulo 2^ADDR_WIDTH.
module vex_memory_operand_address import vmoa_pkg::*; #(
  parameter int ADDR_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [3:0]            reg_select,
  input  logic [63:0]           reg_value,
  input  logic [63:0]           instr_addr,
  input  logic [1:0]            prefix_len,
  input  logic                  vex_b,
  input  logic                  vex_x,
  input  logic [4:0]            vex_map,
  input  logic [7:0]            opcode,
  input  logic [7:0]            modrm,
  input  logic [39:0]           tail_bytes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_WIDTH-1:0] eff_addr,
  output logic [3:0]            instr_length
);

  dec_t                  dec;
  dec_t                  s1_dec;
  logic                  s1_valid;
  logic [ADDR_WIDTH-1:0] s1_ip;
  logic [ADDR_WIDTH-1:0] base_rd;
  logic [ADDR_WIDTH-1:0] index_rd;
  logic                  in_fire;
  logic                  out_load;
  logic                  resolve_fire;
  logic [ADDR_WIDTH-1:0] opa;
  logic [ADDR_WIDTH-1:0] opb;
  logic [ADDR_WIDTH-1:0] addr_next;

  assign out_load     = !out_valid || out_ready;
  assign in_ready     = !s1_valid || out_load;
  assign in_fire      = in_valid && in_ready;
  assign resolve_fire = in_fire && (op == OP_RESOLVE);

  vmoa_decode u_decode (
    .prefix_len (prefix_len),
    .vex_b      (vex_b),
    .vex_x      (vex_x),
    .vex_map    (vex_map),
    .opcode     (opcode),
    .modrm      (modrm),
    .tail_bytes (tail_bytes),
    .dec        (dec)
  );

  vmoa_regfile #(
    .DATA_WIDTH (ADDR_WIDTH)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_fire && (op == OP_WRITE)),
    .wr_sel    (reg_select),
    .wr_data   (reg_value[ADDR_WIDTH-1:0]),
    .rd_en     (resolve_fire),
    .rd_sel_a  (dec.base_sel),
    .rd_sel_b  (dec.index_sel),
    .rd_data_a (base_rd),
    .rd_data_b (index_rd)
  );

  // Decode stage, held alongside the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= resolve_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_fire) begin
      s1_dec <= dec;
      s1_ip  <= instr_addr[ADDR_WIDTH-1:0];
    end
  end

  // RIP-relative forms add the instruction length in place of the scaled index.
  always_comb begin
    if (s1_dec.rip_rel) begin
      opa = s1_ip;
      opb = ADDR_WIDTH'(s1_dec.length);
    end else begin
      opa = s1_dec.use_base ? base_rd : '0;
      opb = s1_dec.use_index ? (index_rd << s1_dec.scale) : '0;
    end
    addr_next = opa + opb + ADDR_WIDTH'(s1_dec.disp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      eff_addr     <= addr_next;
      instr_length <= s1_dec.length;
    end
  end

endmodule
